// File: rtl/stereo_chorus_modulated_delay_assert.svh
// Assertion macros for the stereo chorus block.
// Used by the port checker; expects clk and rst in scope.
`ifndef STEREO_CHORUS_MODULATED_DELAY_ASSERT_SVH
`define STEREO_CHORUS_MODULATED_DELAY_ASSERT_SVH

// same-cycle implication, off during reset
`define SCMD_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, off during reset
`define SCMD_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/scmd_pkg.sv
// Shared types, constants and the sine table for the stereo chorus.
// No dependencies.
package scmd_pkg;

  localparam int LINE_DEPTH = 4096;
  localparam int ADDR_W     = 12;
  localparam int TAPS_W     = 13;
  localparam int DEV_W      = 11;
  localparam int SAMPLE_W   = 16;
  localparam int FRAC_W     = 8;
  localparam int SINE_N     = 1024;
  localparam int SINE_IDX_W = 10;
  localparam int LFO_W      = 17;
  localparam int PROD_W     = DEV_W + 1 + LFO_W;
  localparam int OFFSET_W   = PROD_W - FRAC_W;
  localparam int POS_W      = TAPS_W + FRAC_W + 1;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_DELAY_TAPS     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_DEVIATION  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LFO_PHASE_STEP = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LFO_SHAPE      = 3'd3;

  localparam logic [TAPS_W-1:0] TAPS_RESET  = 13'd1024;
  localparam logic [DEV_W-1:0]  DEV_RESET   = 11'd128;
  localparam logic [31:0]       STEP_RESET  = 32'd429497;
  localparam logic [TAPS_W-1:0] TAPS_MIN    = 13'd2;
  localparam logic [TAPS_W-1:0] TAPS_MAX    = 13'd4096;

  typedef enum logic [1:0] {F_IDLE, F_MUL, F_POS, F_PUSH} front_state_t;
  typedef enum logic [2:0] {B_IDLE, B_RD_OLD, B_RD_NEW, B_LEFT, B_RIGHT, B_OUT} back_state_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] left_sample;
    logic [SAMPLE_W-1:0] right_sample;
    logic [ADDR_W-1:0]   wp;
    logic [ADDR_W-1:0]   older;
    logic [ADDR_W-1:0]   newer;
    logic [FRAC_W-1:0]   frac;
  } entry_t;

  typedef logic [LFO_W-1:0] sine_tab_t [SINE_N];

  function automatic longint unsigned quarter_sine(input longint unsigned t);
    longint unsigned t2;
    longint unsigned p;
    t2 = (t * t) >> 16;
    p = 64'd5223 - ((t2 * 64'd307) >> 16);
    p = 64'd42334 - ((t2 * p) >> 16);
    p = 64'd102944 - ((t2 * p) >> 16);
    p = (t * p) >> 16;
    if (p > 64'd65536) p = 64'd65536;
    return p;
  endfunction

  function automatic sine_tab_t build_sine();
    sine_tab_t tab;
    longint unsigned a;
    longint unsigned quad;
    longint unsigned t;
    longint unsigned s;
    longint unsigned u;
    for (int i = 0; i < SINE_N; i++) begin
      a = (longint'(i) * 64'd262144) / SINE_N;
      quad = (a >> 16) & 64'd3;
      t = a & 64'hFFFF;
      s = quad[0] ? quarter_sine(64'd65536 - t) : quarter_sine(t);
      u = quad[1] ? (64'd65536 - s) >> 1 : (64'd65536 + s) >> 1;
      tab[i] = u[LFO_W-1:0];
    end
    return tab;
  endfunction

  localparam sine_tab_t SINE_TAB = build_sine();

endpackage

// File: rtl/scmd_in_if.sv
// Input channel: one stereo sample pair per word.
// Depends on scmd_pkg.
interface scmd_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [scmd_pkg::SAMPLE_W-1:0] left_sample;
  logic signed [scmd_pkg::SAMPLE_W-1:0] right_sample;
  modport source (output valid, output left_sample, output right_sample, input ready);
  modport sink (input valid, input left_sample, input right_sample, output ready);
endinterface

// File: rtl/scmd_out_if.sv
// Output channel: one processed stereo pair per word.
// Depends on scmd_pkg.
interface scmd_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [scmd_pkg::SAMPLE_W-1:0] left_out;
  logic signed [scmd_pkg::SAMPLE_W-1:0] right_out;
  modport source (output valid, output left_out, output right_out, input ready);
  modport sink (input valid, input left_out, input right_out, output ready);
endinterface

// File: rtl/scmd_front.sv
// Front end: config registers, LFO, read position and tap split.
// Depends on scmd_pkg and scmd_in_if.
module scmd_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [scmd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [scmd_pkg::CFG_DATA_W-1:0] cfg_data,
  scmd_in_if.sink                         audio_in,
  output logic                            push_valid,
  input  logic                            push_ready,
  output scmd_pkg::entry_t                push_data
);

  logic [scmd_pkg::TAPS_W-1:0]   delay_taps;
  logic [scmd_pkg::DEV_W-1:0]    max_deviation;
  logic [31:0]                   lfo_phase_step;
  logic                          lfo_shape;
  logic [scmd_pkg::ADDR_W-1:0]   wp;
  logic [31:0]                   lfo_phase;
  scmd_pkg::front_state_t        state, state_next;
  logic [scmd_pkg::SAMPLE_W-1:0] left_hold, right_hold;
  logic [scmd_pkg::LFO_W-1:0]    sine_q;
  logic [scmd_pkg::PROD_W-1:0]   product;
  scmd_pkg::entry_t              entry;

  logic [scmd_pkg::TAPS_W-1:0]   taps_eff;
  logic [scmd_pkg::DEV_W-1:0]    dev_lim, dev_nz, dev_eff;
  logic [scmd_pkg::ADDR_W-1:0]   wp_fix, wp_inc;
  logic [scmd_pkg::TAPS_W-1:0]   wp_inc_w;
  logic [scmd_pkg::LFO_W-1:0]    lfo_tri, lfo;
  logic [scmd_pkg::POS_W-1:0]    pos, limit, pos_w;
  logic [scmd_pkg::TAPS_W-1:0]   newer_w;
  logic                          accept;

  always_comb begin
    if (delay_taps < scmd_pkg::TAPS_MIN) taps_eff = scmd_pkg::TAPS_MIN;
    else if (delay_taps > scmd_pkg::TAPS_MAX) taps_eff = scmd_pkg::TAPS_MAX;
    else taps_eff = delay_taps;
    dev_lim = scmd_pkg::DEV_W'((taps_eff - 13'd1) >> 1);
    dev_nz  = (max_deviation == '0) ? scmd_pkg::DEV_W'(1) : max_deviation;
    dev_eff = (dev_nz > dev_lim) ? dev_lim : dev_nz;
    wp_fix  = ({1'b0, wp} >= taps_eff) ? '0 : wp;
    wp_inc_w = {1'b0, wp} + 13'd1;
    wp_inc  = (wp_inc_w >= taps_eff) ? '0 : wp_inc_w[scmd_pkg::ADDR_W-1:0];
    lfo_tri = lfo_phase[31] ? scmd_pkg::LFO_W'(18'h20000 - {1'b0, lfo_phase[31:15]})
                            : lfo_phase[31:15];
    lfo     = lfo_shape ? lfo_tri : sine_q;
    pos     = scmd_pkg::POS_W'({wp, {scmd_pkg::FRAC_W{1'b0}}})
            + scmd_pkg::POS_W'(product[scmd_pkg::PROD_W-1:scmd_pkg::FRAC_W]);
    limit   = scmd_pkg::POS_W'({taps_eff, {scmd_pkg::FRAC_W{1'b0}}});
    pos_w   = (pos >= limit) ? pos - limit : pos;
    newer_w = scmd_pkg::TAPS_W'(pos_w[scmd_pkg::FRAC_W +: scmd_pkg::ADDR_W]) + 13'd1;
    if (newer_w >= taps_eff) newer_w = '0;
  end

  assign accept = audio_in.valid && audio_in.ready;

  always_comb begin
    state_next = state;
    case (state)
      scmd_pkg::F_IDLE: if (accept) state_next = scmd_pkg::F_MUL;
      scmd_pkg::F_MUL:  state_next = scmd_pkg::F_POS;
      scmd_pkg::F_POS:  state_next = scmd_pkg::F_PUSH;
      scmd_pkg::F_PUSH: if (push_ready) state_next = scmd_pkg::F_IDLE;
      default:          state_next = scmd_pkg::F_IDLE;
    endcase
  end

  always_comb begin
    audio_in.ready = (state == scmd_pkg::F_IDLE) && !rst;
    push_valid     = (state == scmd_pkg::F_PUSH);
    push_data      = entry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= scmd_pkg::F_IDLE;
      delay_taps     <= scmd_pkg::TAPS_RESET;
      max_deviation  <= scmd_pkg::DEV_RESET;
      lfo_phase_step <= scmd_pkg::STEP_RESET;
      lfo_shape      <= 1'b0;
      wp             <= '0;
      lfo_phase      <= '0;
    end else begin
      state <= state_next;
      if (cfg_write) begin
        case (cfg_index)
          scmd_pkg::REG_DELAY_TAPS:     delay_taps <= cfg_data[scmd_pkg::TAPS_W-1:0];
          scmd_pkg::REG_MAX_DEVIATION:  max_deviation <= cfg_data[scmd_pkg::DEV_W-1:0];
          scmd_pkg::REG_LFO_PHASE_STEP: lfo_phase_step <= cfg_data[31:0];
          scmd_pkg::REG_LFO_SHAPE:      lfo_shape <= cfg_data[0];
          default: ;
        endcase
      end
      if (accept) wp <= wp_fix;
      if (state == scmd_pkg::F_PUSH && push_ready) begin
        wp        <= wp_inc;
        lfo_phase <= lfo_phase + lfo_phase_step;
      end
    end
  end

  always_ff @(posedge clk) begin
    sine_q <= scmd_pkg::SINE_TAB[lfo_phase[31 -: scmd_pkg::SINE_IDX_W]];
    if (accept) begin
      left_hold  <= audio_in.left_sample;
      right_hold <= audio_in.right_sample;
    end
    if (state == scmd_pkg::F_MUL) product <= {dev_eff, 1'b0} * lfo;
    if (state == scmd_pkg::F_POS) begin
      entry.left_sample  <= left_hold;
      entry.right_sample <= right_hold;
      entry.wp           <= wp;
      entry.older        <= pos_w[scmd_pkg::FRAC_W +: scmd_pkg::ADDR_W];
      entry.newer        <= newer_w[scmd_pkg::ADDR_W-1:0];
      entry.frac         <= pos_w[scmd_pkg::FRAC_W-1:0];
    end
  end

endmodule

// File: rtl/scmd_fifo.sv
// Two-word queue between front and back end.
// Depends on scmd_pkg.
module scmd_fifo (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  scmd_pkg::entry_t push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output scmd_pkg::entry_t pop_data
);

  scmd_pkg::entry_t slots [2];
  logic             wr_ptr, rd_ptr;
  logic [1:0]       count;
  logic             do_push, do_pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_data   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= !wr_ptr;
      if (do_pop) rd_ptr <= !rd_ptr;
      if (do_push && !do_pop) count <= count + 2'd1;
      else if (do_pop && !do_push) count <= count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push_data;
  end

endmodule

// File: rtl/scmd_back.sv
// Back end: delay line memories, interpolation, mix and output register.
// Depends on scmd_pkg and scmd_out_if.
module scmd_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             pop_valid,
  output logic             pop_ready,
  input  scmd_pkg::entry_t pop_data,
  scmd_out_if.source       audio_out
);

  logic [scmd_pkg::SAMPLE_W-1:0] left_mem  [scmd_pkg::LINE_DEPTH];
  logic [scmd_pkg::SAMPLE_W-1:0] right_mem [scmd_pkg::LINE_DEPTH];
  logic [scmd_pkg::TAPS_W-1:0]   fill;
  scmd_pkg::back_state_t         state, state_next;
  scmd_pkg::entry_t              cur;
  logic [scmd_pkg::ADDR_W-1:0]   rd_addr;
  logic [scmd_pkg::SAMPLE_W-1:0] left_q, right_q;
  logic                          q_ok;
  logic [scmd_pkg::SAMPLE_W-1:0] left_a, right_a, left_b, right_b;
  logic [scmd_pkg::SAMPLE_W-1:0] left_echo, right_echo;
  logic [scmd_pkg::SAMPLE_W-1:0] left_echo_next, right_echo_next;
  logic [scmd_pkg::FRAC_W:0]     frac_inv;
  logic [scmd_pkg::SAMPLE_W-1:0] left_in_b, right_in_b;
  logic [scmd_pkg::SAMPLE_W:0]   left_sum, right_sum;
  logic [scmd_pkg::SAMPLE_W-1:0] left_res, right_res;
  logic                          out_valid, load_out;
  logic [scmd_pkg::SAMPLE_W+scmd_pkg::FRAC_W:0] left_acc, right_acc;

  function automatic logic [scmd_pkg::SAMPLE_W-1:0] flip(
    input logic [scmd_pkg::SAMPLE_W-1:0] x);
    return {~x[scmd_pkg::SAMPLE_W-1], x[scmd_pkg::SAMPLE_W-2:0]};
  endfunction

  always_comb begin
    rd_addr  = (state == scmd_pkg::B_RD_OLD) ? cur.older : cur.newer;
    left_b   = flip(q_ok ? left_q : '0);
    right_b  = flip(q_ok ? right_q : '0);
    frac_inv = (scmd_pkg::FRAC_W+1)'(1 << scmd_pkg::FRAC_W) - {1'b0, cur.frac};
    left_acc = (scmd_pkg::SAMPLE_W+scmd_pkg::FRAC_W+1)'(left_a * frac_inv)
             + (scmd_pkg::SAMPLE_W+scmd_pkg::FRAC_W+1)'(left_b * cur.frac);
    right_acc = (scmd_pkg::SAMPLE_W+scmd_pkg::FRAC_W+1)'(right_a * frac_inv)
              + (scmd_pkg::SAMPLE_W+scmd_pkg::FRAC_W+1)'(right_b * cur.frac);
    left_echo_next  = left_acc[scmd_pkg::FRAC_W +: scmd_pkg::SAMPLE_W];
    right_echo_next = right_acc[scmd_pkg::FRAC_W +: scmd_pkg::SAMPLE_W];
    left_in_b  = flip(cur.left_sample);
    right_in_b = flip(cur.right_sample);
    left_sum   = {1'b0, left_in_b} + {1'b0, left_echo};
    right_sum  = {1'b0, right_in_b} + {1'b0, right_echo};
    left_res   = flip(left_sum[scmd_pkg::SAMPLE_W:1]);
    right_res  = flip(right_sum[scmd_pkg::SAMPLE_W:1]);
  end

  always_comb begin
    state_next = state;
    case (state)
      scmd_pkg::B_IDLE:   if (pop_valid) state_next = scmd_pkg::B_RD_OLD;
      scmd_pkg::B_RD_OLD: state_next = scmd_pkg::B_RD_NEW;
      scmd_pkg::B_RD_NEW: state_next = scmd_pkg::B_LEFT;
      scmd_pkg::B_LEFT:   state_next = scmd_pkg::B_RIGHT;
      scmd_pkg::B_RIGHT:  state_next = scmd_pkg::B_OUT;
      scmd_pkg::B_OUT:    if (!out_valid || audio_out.ready) state_next = scmd_pkg::B_IDLE;
      default:            state_next = scmd_pkg::B_IDLE;
    endcase
  end

  always_comb begin
    pop_ready       = (state == scmd_pkg::B_IDLE);
    load_out        = (state == scmd_pkg::B_OUT) && (!out_valid || audio_out.ready);
    audio_out.valid = out_valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= scmd_pkg::B_IDLE;
      out_valid <= 1'b0;
      fill      <= '0;
    end else begin
      state <= state_next;
      if (load_out) out_valid <= 1'b1;
      else if (audio_out.ready) out_valid <= 1'b0;
      if (state == scmd_pkg::B_RIGHT && {1'b0, cur.wp} >= fill)
        fill <= {1'b0, cur.wp} + 13'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (state == scmd_pkg::B_RD_OLD || state == scmd_pkg::B_RD_NEW) begin
      left_q  <= left_mem[rd_addr];
      right_q <= right_mem[rd_addr];
      q_ok    <= ({1'b0, rd_addr} < fill);
    end
    if (state == scmd_pkg::B_RIGHT) begin
      left_mem[cur.wp]  <= cur.left_sample;
      right_mem[cur.wp] <= cur.right_sample;
    end
  end

  always_ff @(posedge clk) begin
    if (pop_valid && pop_ready) cur <= pop_data;
    if (state == scmd_pkg::B_RD_NEW) begin
      left_a  <= left_b;
      right_a <= right_b;
    end
    if (state == scmd_pkg::B_LEFT) left_echo <= left_echo_next;
    if (state == scmd_pkg::B_RIGHT) right_echo <= right_echo_next;
    if (load_out) begin
      audio_out.left_out  <= left_res;
      audio_out.right_out <= right_res;
    end
  end

endmodule

// File: rtl/stereo_chorus_modulated_delay.sv
// Stereo chorus: each input word is a left/right sample pair and yields one
// output pair, the mean of the input and a linearly interpolated echo read
// from a 4096-sample delay line per channel at a sine or triangle LFO offset.
// The front end steps through accept, offset multiply, position wrap and
// queue push for each word; the back end, which has a single read port per
// delay line, steps through queue pop, two tap reads, two interpolation steps
// with the line write in the second, and output load. It pops a new word only
// after the output load, which waits while a held output word is not taken.
// Delay lines read as zero until written; no clearing pass is needed after
// reset. Config writes belong in idle.
module stereo_chorus_modulated_delay (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [scmd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [scmd_pkg::CFG_DATA_W-1:0] cfg_data,
  scmd_in_if.sink                         audio_in,
  scmd_out_if.source                      audio_out
);

  logic             push_valid, push_ready, pop_valid, pop_ready;
  scmd_pkg::entry_t push_data, pop_data;

  scmd_front u_front (
    .clk, .rst, .cfg_write, .cfg_index, .cfg_data, .audio_in,
    .push_valid, .push_ready, .push_data
  );

  scmd_fifo u_fifo (
    .clk, .rst, .push_valid, .push_ready, .push_data,
    .pop_valid, .pop_ready, .pop_data
  );

  scmd_back u_back (
    .clk, .rst, .pop_valid, .pop_ready, .pop_data, .audio_out
  );

endmodule

// File: rtl/scmd_checker.sv
// Port checker for the stereo chorus, bound to the top level.
// Depends on scmd_pkg and the assertion macro header.
`include "stereo_chorus_modulated_delay_assert.svh"

module scmd_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [scmd_pkg::SAMPLE_W-1:0] out_left,
  input logic [scmd_pkg::SAMPLE_W-1:0] out_right
);

  logic [2:0] outstanding;

  always_ff @(posedge clk) begin
    if (rst) begin
      outstanding <= '0;
    end else begin
      outstanding <= outstanding + {2'b0, in_valid && in_ready}
                   - {2'b0, out_valid && out_ready};
    end
  end

  `SCMD_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "output word dropped")
  `SCMD_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_left) && $stable(out_right), "stalled word changed")
  `SCMD_IMPLY(a_no_phantom, out_valid, outstanding != 3'd0, "output without pending input")
  `SCMD_IMPLY(a_bounded, 1'b1, outstanding <= 3'd5, "too many words in flight")

endmodule

bind stereo_chorus_modulated_delay scmd_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (audio_in.valid),
  .in_ready  (audio_in.ready),
  .out_valid (audio_out.valid),
  .out_ready (audio_out.ready),
  .out_left  (audio_out.left_out),
  .out_right (audio_out.right_out)
);
